// ===== design/ibprng_pkg.sv =====
// Shared constants for the inversive byte generator.
package ibprng_pkg;

    localparam int unsigned WORD_W        = 64;
    localparam int unsigned HALF_W        = WORD_W / 2;
    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned POS_W         = 3;
    localparam int unsigned CNT_W         = 7;
    localparam int unsigned TZ_W          = 6;
    localparam int unsigned DEF_INV_ROUNDS = 6;

    localparam logic [CNT_W-1:0]  MAX_REQUEST = 7'd64;
    localparam logic [POS_W-1:0]  LAST_POS    = 3'd7;
    localparam logic [WORD_W-1:0] WORD_RESET  = 64'h05fd_8167_b327_f30f;
    localparam logic [WORD_W-1:0] WORD_ADDEND = 64'hc05a_a570_4efb_c79f;

endpackage

// ===== design/ibprng_inv.sv =====
// Iterative modular inverse of a 64-bit word around one shared 32x32 multiplier.
module ibprng_inv
    import ibprng_pkg::*;
#(
    parameter int unsigned INVERSE_ROUNDS = DEF_INV_ROUNDS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [WORD_W-1:0] i_word,
    output logic              o_done,
    output logic [WORD_W-1:0] o_result
);

    localparam int unsigned RND_W = $clog2(INVERSE_ROUNDS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_STRIP,
        S_MUL,
        S_OUT
    } t_state;

    t_state              r_state;
    logic [WORD_W-1:0]   r_y;
    logic [TZ_W-1:0]     r_tz;
    logic [WORD_W-1:0]   r_r;
    logic [WORD_W-1:0]   r_q;
    logic [WORD_W-1:0]   r_qp1;
    logic [WORD_W-1:0]   r_acc;
    logic [RND_W-1:0]    r_round;
    logic [2:0]          r_step;
    logic                r_done;
    logic [WORD_W-1:0]   r_res;

    logic [WORD_W-1:0]   op_a;
    logic [WORD_W-1:0]   op_b;
    logic [1:0]          phase;
    logic [HALF_W-1:0]   mul_a;
    logic [HALF_W-1:0]   mul_b;
    logic [WORD_W-1:0]   prod;
    logic [WORD_W-1:0]   cross_sum;

    // Steps 0..2 form r * (1 + q), steps 3..5 form q * q, step 6 refreshes 1 + q.
    always_comb begin
        op_a  = (r_step < 3'd3) ? r_r   : r_q;
        op_b  = (r_step < 3'd3) ? r_qp1 : r_q;
        case (r_step)
            3'd0, 3'd3: phase = 2'd0;
            3'd1, 3'd4: phase = 2'd1;
            3'd2, 3'd5: phase = 2'd2;
            default:    phase = 2'd0;
        endcase
        mul_a     = (phase == 2'd2) ? op_a[WORD_W-1:HALF_W] : op_a[HALF_W-1:0];
        mul_b     = (phase == 2'd1) ? op_b[WORD_W-1:HALF_W] : op_b[HALF_W-1:0];
        prod      = WORD_W'(mul_a) * WORD_W'(mul_b);
        cross_sum = r_acc + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_step  <= '0;
            r_round <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_y  <= i_word;
                        r_tz <= '0;
                        r_r  <= '0;
                        r_state <= (i_word == '0) ? S_OUT : S_STRIP;
                    end
                end
                S_STRIP: begin
                    if (r_y[BYTE_W-1:0] == '0) begin
                        r_y  <= r_y >> BYTE_W;
                        r_tz <= r_tz + TZ_W'(BYTE_W);
                    end else if (!r_y[0]) begin
                        r_y  <= r_y >> 1;
                        r_tz <= r_tz + TZ_W'(1);
                    end else begin
                        r_r     <= WORD_W'(1);
                        r_q     <= WORD_W'(1) - r_y;
                        r_qp1   <= WORD_W'(2) - r_y;
                        r_step  <= '0;
                        r_round <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    case (r_step)
                        3'd0, 3'd3: begin
                            r_acc  <= prod;
                            r_step <= r_step + 3'd1;
                        end
                        3'd1, 3'd4: begin
                            r_acc  <= cross_sum;
                            r_step <= r_step + 3'd1;
                        end
                        3'd2: begin
                            r_r    <= cross_sum;
                            r_step <= r_step + 3'd1;
                        end
                        3'd5: begin
                            r_q    <= cross_sum;
                            r_step <= r_step + 3'd1;
                        end
                        3'd6: begin
                            r_qp1  <= r_q + WORD_W'(1);
                            r_step <= '0;
                            if (r_round == RND_W'(INVERSE_ROUNDS - 1)) begin
                                r_state <= S_OUT;
                            end else begin
                                r_round <= r_round + RND_W'(1);
                            end
                        end
                        default: r_step <= '0;
                    endcase
                end
                S_OUT: begin
                    r_res   <= r_r << r_tz;
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

// ===== design/inversive_byte_prng.sv =====
// Top level of the inversive congruential byte generator.
//
// Each input transfer carries a byte count in i_s_tdata[6:0]; counts above 64 are
// treated as 64 and a count of zero produces no output. The block then sends that
// many bytes, one output transfer each, taken from a 64-bit generator word low byte
// first and continuing from wherever the previous request stopped; o_m_tlast marks
// the final byte of each request. Bytes go out at one per cycle while the consumer
// is ready and no word update holds the output. After the eighth byte of a word
// the word is replaced by its inverse (modulo 2^64, with trailing zero bits carried
// through) plus a fixed constant. That update runs in an iterative unit built around
// a single 32x32 multiplier: it takes the word, strips trailing zeros, runs
// INVERSE_ROUNDS inversion rounds (6 at the default) and finishes, and a zero word
// skips straight to the finish. The output stays idle during each word update, and a
// full 64-byte request crosses eight word updates. The input side is ready only
// while no request is in progress, including a word update that follows the final
// byte of a request.
module inversive_byte_prng
    import ibprng_pkg::*;
#(
    parameter int unsigned INVERSE_ROUNDS = DEF_INV_ROUNDS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [6:0] byte_count, [7] zero
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] random_byte
    output logic       o_m_tlast    // last_byte
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMIT,
        ST_ADVANCE
    } t_state;

    t_state             r_state;
    logic [WORD_W-1:0]  r_word;
    logic [POS_W-1:0]   r_pos;
    logic [CNT_W-1:0]   r_left;
    logic               r_inv_start;

    logic [CNT_W-1:0]   req_count;
    logic               inv_done;
    logic [WORD_W-1:0]  inv_result;

    // Requests above the limit are clipped to it.
    assign req_count = (i_s_tdata[CNT_W-1:0] > MAX_REQUEST) ? MAX_REQUEST
                                                             : i_s_tdata[CNT_W-1:0];

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = (r_state == ST_EMIT);
    assign o_m_tdata  = r_word[{r_pos, 3'b000} +: BYTE_W];
    assign o_m_tlast  = (r_left == CNT_W'(1));

    ibprng_inv #(
        .INVERSE_ROUNDS (INVERSE_ROUNDS)
    ) u_inv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_inv_start),
        .i_word   (r_word),
        .o_done   (inv_done),
        .o_result (inv_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_word      <= WORD_RESET;
            r_pos       <= '0;
            r_left      <= '0;
            r_inv_start <= 1'b0;
        end else begin
            r_inv_start <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_s_tvalid && (req_count != '0)) begin
                        r_left  <= req_count;
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (i_m_tready) begin
                        r_left <= r_left - CNT_W'(1);
                        if (r_pos == LAST_POS) begin
                            // The word is used up: refresh it before anything else.
                            r_inv_start <= 1'b1;
                            r_state     <= ST_ADVANCE;
                        end else begin
                            r_pos <= r_pos + POS_W'(1);
                            if (r_left == CNT_W'(1)) begin
                                r_state <= ST_IDLE;
                            end
                        end
                    end
                end
                ST_ADVANCE: begin
                    if (inv_done) begin
                        r_word  <= inv_result + WORD_ADDEND;
                        r_pos   <= '0;
                        r_state <= (r_left != '0) ? ST_EMIT : ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== design/ibprng_checker.sv =====
// Port-level checks for the inversive byte generator, bound to the top level.
module ibprng_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_tvalid,
    input logic       o_s_tready,
    input logic [7:0] i_s_tdata,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata,
    input logic       o_m_tlast
);

    // A request is never taken while bytes of another are still pending.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !o_s_tready)
        else $error("input ready while output is valid");

    // A nonzero request starts sending bytes right away.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && (i_s_tdata[6:0] != 7'd0)) |=> o_m_tvalid)
        else $error("request did not start output");

    // A zero request produces nothing.
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && (i_s_tdata[6:0] == 7'd0)) |=> !o_m_tvalid)
        else $error("zero request produced output");

    // Nothing follows the last byte of a run.
    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && o_m_tlast) |=> !o_m_tvalid)
        else $error("output continued after last byte");

    // A stalled byte holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled output changed");

endmodule

bind inversive_byte_prng ibprng_checker u_ibprng_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the inversive congruential byte generator.
module tb;
    import ibprng_pkg::*;

    localparam int unsigned RANDOM_NONZERO  = 395;
    localparam int unsigned IDLE_PCT        = 36;
    localparam int unsigned HOLD_OFF_AT     = 1500;
    localparam int unsigned HOLD_OFF_CYCLES = 500;
    localparam int unsigned TAIL_CYCLES     = 120;
    localparam int unsigned CYCLE_LIMIT     = 1_500_000;
    localparam int unsigned REPORT_LIMIT    = 10;

    // Directed requests: single bytes, runs that end just short of, exactly on and
    // just past a word boundary, the largest legal count, oversized counts that must
    // saturate (127 also sets every count bit), and empty requests that must leave
    // the generator untouched.
    localparam int DIRECTED_COUNTS [22] = '{
        1, 0, 7, 8, 9, 64, 65, 127, 2, 3, 0, 63, 1, 100, 16, 5, 64, 11, 127, 4, 66, 8
    };

    typedef struct {
        logic [CNT_W-1:0] count;
        bit               wait_empty;
    } t_request;

    typedef struct {
        logic [BYTE_W-1:0] value;
        logic              last;
    } t_byte_expect;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = '0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;

    t_request     pending_requests [$];
    t_byte_expect expected_bytes [$];

    // Private copy of the generator state, advanced as requests are accepted.
    logic [WORD_W-1:0] gen_word;
    logic [POS_W-1:0]  gen_pos;

    int unsigned bytes_promised   = 0;
    int unsigned results_checked  = 0;
    int unsigned bytes_seen       = 0;
    int unsigned requests_taken   = 0;
    int unsigned empty_requests   = 0;
    int unsigned oversized_reqs   = 0;
    int unsigned words_advanced   = 0;
    int unsigned miss_count       = 0;
    int unsigned hold_left        = 0;
    bit          hold_done        = 1'b0;
    int unsigned cycle_count      = 0;

    inversive_byte_prng u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // Inverse modulo 2^64 with the trailing zero bits carried through: the odd part
    // is inverted by the product series and the result shifted back up.
    function automatic logic [WORD_W-1:0] inverse_keep_twos(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] odd;
        logic [WORD_W-1:0] r;
        logic [WORD_W-1:0] q;
        int unsigned       tz;
        int unsigned       k;
        if (w == '0) begin
            return '0;
        end
        odd = w;
        tz  = 0;
        while (!odd[0]) begin
            odd = odd >> 1;
            tz++;
        end
        r = 64'd1;
        q = 64'd1 - odd;
        for (k = 0; k < DEF_INV_ROUNDS; k++) begin
            r = r * (64'd1 + q);
            q = q * q;
        end
        return r << tz;
    endfunction

    // Works out the bytes that one accepted request produces and queues them.
    task automatic queue_request_bytes(input logic [CNT_W-1:0] count,
                                       output int unsigned added);
        int unsigned n;
        int unsigned k;
        t_byte_expect e;
        n = (count > MAX_REQUEST) ? MAX_REQUEST : count;
        for (k = 0; k < n; k++) begin
            e.value = gen_word[8*gen_pos +: 8];
            e.last  = (k == n - 1);
            expected_bytes.push_back(e);
            if (gen_pos == LAST_POS) begin
                gen_word = inverse_keep_twos(gen_word) + WORD_ADDEND;
                gen_pos  = '0;
                words_advanced++;
            end else begin
                gen_pos = gen_pos + 1'b1;
            end
        end
        added = n;
    endtask

    task automatic report_miss(input string msg);
        miss_count++;
        if (miss_count <= REPORT_LIMIT) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
    endtask

    function automatic logic [CNT_W-1:0] pick_count();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 12) begin
            return '0;
        end
        if (roll < 62) begin
            return CNT_W'($urandom_range(16, 1));
        end
        if (roll < 92) begin
            return CNT_W'($urandom_range(64, 17));
        end
        return CNT_W'($urandom_range(127, 65));
    endfunction

    // Request driver. A held request stays on the bus until its transfer; a request
    // flagged to wait is not offered until every promised byte has been checked.
    always @(posedge clk) begin
        int unsigned      added;
        logic             next_valid;
        logic [CNT_W-1:0] next_count;
        bit               steady;
        bit               drained;
        if (!rst_n) begin
            s_tvalid       <= 1'b0;
            s_tdata        <= '0;
            bytes_promised <= 0;
            gen_word       = WORD_RESET;
            gen_pos        = '0;
        end else begin
            added      = 0;
            next_valid = s_tvalid;
            next_count = s_tdata[CNT_W-1:0];
            if (s_tvalid && s_tready) begin
                queue_request_bytes(s_tdata[CNT_W-1:0], added);
                requests_taken++;
                if (s_tdata[CNT_W-1:0] == '0) begin
                    empty_requests++;
                end
                if (s_tdata[CNT_W-1:0] > MAX_REQUEST) begin
                    oversized_reqs++;
                end
                next_valid = 1'b0;
            end
            // A run of requests with no sender gaps at all.
            steady  = (requests_taken >= 150) && (requests_taken < 230);
            drained = (results_checked == bytes_promised + added);
            if (!next_valid && pending_requests.size() > 0 &&
                    (!pending_requests[0].wait_empty || drained) &&
                    (steady || $urandom_range(99) >= IDLE_PCT)) begin
                next_valid = 1'b1;
                next_count = pending_requests.pop_front().count;
            end
            s_tvalid       <= next_valid;
            s_tdata        <= {1'b0, next_count};
            bytes_promised <= bytes_promised + added;
        end
    end

    // Long receiver hold-off, started once after enough bytes have gone by, so the
    // block stalls mid-request while the next request waits at its input.
    always @(posedge clk) begin
        if (!rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && bytes_seen >= HOLD_OFF_AT) begin
            hold_left <= HOLD_OFF_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Byte monitor and checker.
    always @(posedge clk) begin
        t_byte_expect want;
        bit           steady;
        if (!rst_n) begin
            m_tready        <= 1'b0;
            results_checked <= 0;
            bytes_seen      <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                bytes_seen <= bytes_seen + 1;
                if (results_checked >= bytes_promised) begin
                    report_miss($sformatf("unexpected byte %h last %b", m_tdata, m_tlast));
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_tdata !== want.value || m_tlast !== want.last) begin
                        report_miss($sformatf(
                            "byte %0d: expected data %h last %b, got data %h last %b",
                            results_checked, want.value, want.last, m_tdata, m_tlast));
                    end
                    results_checked <= results_checked + 1;
                end
            end
            steady = (bytes_seen >= 3000) && (bytes_seen < 4500);
            if (hold_left != 0) begin
                m_tready <= 1'b0;
            end else if (steady) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d bytes outstanding.",
                     cycle_count, bytes_promised - results_checked);
            $display("tb failed");
            $finish;
        end
    end

    initial begin
        t_request    r;
        int unsigned nonzero;
        int unsigned k;
        foreach (DIRECTED_COUNTS[i]) begin
            r.count      = CNT_W'(DIRECTED_COUNTS[i]);
            r.wait_empty = 1'b0;
            pending_requests.push_back(r);
        end
        // Random part; two of its requests wait for the generator to drain first.
        nonzero = 0;
        k       = 0;
        while (nonzero < RANDOM_NONZERO) begin
            r.count      = pick_count();
            r.wait_empty = (k == 0) || (k == 250);
            pending_requests.push_back(r);
            if (r.count != '0) begin
                nonzero++;
            end
            k++;
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_requests.size() != 0 || s_tvalid) begin
            @(posedge clk);
        end
        while (results_checked != bytes_promised) begin
            @(posedge clk);
        end
        // The block may still be advancing the word after the final byte.
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Checked %0d bytes from %0d requests (%0d empty, %0d oversized), %0d words.",
                 results_checked, requests_taken, empty_requests, oversized_reqs,
                 words_advanced);
        $display("Exercised a %0d-cycle receiver hold-off and drained pauses; %0d mismatches.",
                 HOLD_OFF_CYCLES, miss_count);
        if (miss_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/ibprng_pkg.sv
design/ibprng_inv.sv
design/inversive_byte_prng.sv
design/ibprng_checker.sv
tb/tb.sv
